>>> rtl/core/serial_switch_command_parser_assert.svh
// Assertion macros shared by the serial switch command parser RTL.
`ifndef SERIAL_SWITCH_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_SWITCH_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SSCP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define SSCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sscp_pkg.sv
// Types and constants of the serial switch command parser.
package sscp_pkg;

   localparam logic [7:0] SYNC_CHAR    = 8'h55;   // 'U'
   localparam logic [7:0] CHAR_O       = 8'h4F;
   localparam logic [7:0] CHAR_N       = 8'h4E;
   localparam logic [7:0] CHAR_F       = 8'h46;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_TWO     = 8'h32;
   localparam logic [7:0] CHAR_THREE   = 8'h33;
   localparam logic [7:0] CHAR_LED     = 8'h4C;   // 'L'

   localparam int POS_WIDTH   = 4;
   localparam int LATCH_WIDTH = 5;

   localparam logic [POS_WIDTH-1:0] FRAME_LEN   = POS_WIDTH'(2 + 4 + 8);
   localparam logic [POS_WIDTH-1:0] POS_SYNC1   = 4'd1;
   localparam logic [POS_WIDTH-1:0] POS_ADDR3   = 4'd5;
   localparam logic [POS_WIDTH-1:0] POS_TARGET  = 4'd10;
   localparam logic [POS_WIDTH-1:0] POS_OPC0    = 4'd11;
   localparam logic [POS_WIDTH-1:0] POS_OPC1    = 4'd12;
   localparam logic [POS_WIDTH-1:0] POS_LAST    = 4'd13;

   typedef enum logic [2:0] {
      ST_BUSY   = 3'd0,
      ST_DROP   = 3'd1,
      ST_OK     = 3'd2,
      ST_BADTGT = 3'd3,
      ST_BADOPC = 3'd4
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [LATCH_WIDTH-1:0] latch_bits;
   } decode_result_type;

endpackage

>>> rtl/core/sscp_decode.sv
// Frame decode: opcode and target check, latch update for a finished frame.
module sscp_decode
   import sscp_pkg::*;
(
   input  logic [7:0]             target_char,
   input  logic [15:0]            opcode_chars,
   input  logic [7:0]             last_char,
   input  logic [LATCH_WIDTH-1:0] latch_bits,
   output decode_result_type      result
);

   logic                   op_on;
   logic                   op_off;
   logic                   target_ok;
   logic [LATCH_WIDTH-1:0] target_mask;

   assign op_on  = (opcode_chars[7:0] == CHAR_O) && (opcode_chars[15:8] == CHAR_N)
                   && (last_char == CHAR_UNDER);
   assign op_off = (opcode_chars[7:0] == CHAR_O) && (opcode_chars[15:8] == CHAR_F)
                   && (last_char == CHAR_F);

   always_comb begin
      target_ok   = 1'b1;
      target_mask = '0;
      case (target_char)
         CHAR_ZERO:  target_mask = 5'b00001;
         CHAR_ONE:   target_mask = 5'b00010;
         CHAR_TWO:   target_mask = 5'b00100;
         CHAR_THREE: target_mask = 5'b01000;
         CHAR_LED:   target_mask = 5'b10000;
         default:    target_ok   = 1'b0;
      endcase
   end

   always_comb begin
      result.latch_bits = latch_bits;
      if (!op_on && !op_off) begin
         result.status = ST_BADOPC;
      end else if (!target_ok) begin
         result.status = ST_BADTGT;
      end else begin
         result.status = ST_OK;
         if (op_on) begin
            result.latch_bits = latch_bits | target_mask;
         end else begin
            result.latch_bits = latch_bits & ~target_mask;
         end
      end
   end

endmodule

>>> rtl/core/serial_switch_command_parser.sv
// Serial switch command parser top level.
//
// Input channel req_*: one received byte per word on req_rx_byte. Each byte
// advances a 14-byte frame parser: two 'U' sync bytes, four address bytes,
// four ignored bytes, a target byte and a three-byte opcode.
// Result channel rsp_*: one word per input byte, carrying rsp_status
// (0 busy, 1 dropped, 2 ok, 3 bad target, 4 bad opcode) and the five output
// latches after that byte on rsp_switch_states.
// csr_*: csr_write_en writes csr_write_data into the unit address; first
// received address byte is bits 7:0. Write only while the block is idle.
// The result word is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle when not stalled; parse state is updated
// in the accept cycle and the result sits in a single output register.
// Stall: while rsp_stall holds a waiting result, req_stall is raised; a new
// byte is taken in the same cycle the waiting result is taken.
// Reset: synchronous, active high; parser waits for the first sync byte,
// address match flag set, latches off, unit address zero, no result pending.
`include "serial_switch_command_parser_assert.svh"

module serial_switch_command_parser
   import sscp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [LATCH_WIDTH-1:0] rsp_switch_states,
   input  logic                   csr_write_en,
   input  logic [31:0]            csr_write_data
);

   logic [31:0]            unit_address_ff;
   logic [POS_WIDTH-1:0]   byte_position_ff,  byte_position_in;
   logic                   address_matched_ff, address_matched_in;
   logic [7:0]             target_char_ff,    target_char_in;
   logic [15:0]            opcode_chars_ff,   opcode_chars_in;
   logic [LATCH_WIDTH-1:0] latch_bits_ff,     latch_bits_in;
   logic                   rsp_valid_ff,      rsp_valid_in;
   status_type             rsp_status_ff,     rsp_status_in;
   logic [LATCH_WIDTH-1:0] rsp_states_ff;

   logic                   req_accept;
   logic [POS_WIDTH-1:0]   pos;
   logic [1:0]             addr_index;
   logic [7:0]             want_byte;
   decode_result_type      dec;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign pos        = (byte_position_ff >= FRAME_LEN) ? '0 : byte_position_ff;
   assign addr_index = pos[1:0] - 2'd2;
   assign want_byte  = unit_address_ff[8*addr_index +: 8];

   sscp_decode u_decode (
      .target_char  (target_char_ff),
      .opcode_chars (opcode_chars_ff),
      .last_char    (req_rx_byte),
      .latch_bits   (latch_bits_ff),
      .result       (dec)
   );

   always_comb begin
      byte_position_in   = byte_position_ff;
      address_matched_in = address_matched_ff;
      target_char_in     = target_char_ff;
      opcode_chars_in    = opcode_chars_ff;
      latch_bits_in      = latch_bits_ff;
      rsp_status_in      = ST_BUSY;
      if (req_accept) begin
         if (pos <= POS_SYNC1) begin
            if (pos == '0) begin
               address_matched_in = 1'b1;
            end
            if (req_rx_byte == SYNC_CHAR) begin
               byte_position_in = pos + 1'b1;
            end else begin
               byte_position_in   = '0;
               address_matched_in = 1'b1;
               rsp_status_in      = ST_DROP;
            end
         end else if (pos <= POS_ADDR3) begin
            if (req_rx_byte != want_byte) begin
               address_matched_in = 1'b0;
            end
            byte_position_in = pos + 1'b1;
         end else if (pos < POS_TARGET) begin
            byte_position_in = pos + 1'b1;
         end else if (pos == POS_TARGET) begin
            target_char_in   = req_rx_byte;
            byte_position_in = pos + 1'b1;
         end else if (pos == POS_OPC0) begin
            opcode_chars_in  = {opcode_chars_ff[15:8], req_rx_byte};
            byte_position_in = pos + 1'b1;
         end else if (pos == POS_OPC1) begin
            opcode_chars_in  = {req_rx_byte, opcode_chars_ff[7:0]};
            byte_position_in = pos + 1'b1;
         end else begin
            if (address_matched_ff) begin
               rsp_status_in = dec.status;
               latch_bits_in = dec.latch_bits;
            end else begin
               rsp_status_in = ST_DROP;
            end
            byte_position_in   = '0;
            address_matched_in = 1'b1;
         end
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_address_ff    <= '0;
         byte_position_ff   <= '0;
         address_matched_ff <= 1'b1;
         target_char_ff     <= '0;
         opcode_chars_ff    <= '0;
         latch_bits_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unit_address_ff <= csr_write_data;
         end
         byte_position_ff   <= byte_position_in;
         address_matched_ff <= address_matched_in;
         target_char_ff     <= target_char_in;
         opcode_chars_ff    <= opcode_chars_in;
         latch_bits_ff      <= latch_bits_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_states_ff <= latch_bits_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_switch_states = rsp_states_ff;

   `SSCP_ASSERT_SAME(a_pos_in_frame, 1'b1, byte_position_ff < FRAME_LEN, "position left frame")
   `SSCP_ASSERT_NEXT(a_last_restarts, req_accept && (pos == POS_LAST),
      (byte_position_ff == '0) && address_matched_ff, "frame end did not restart parser")
   `SSCP_ASSERT_NEXT(a_latch_only_ok, !(req_accept && (rsp_status_in == ST_OK)),
      $stable(latch_bits_ff), "latches changed without a good frame")
   `SSCP_ASSERT_NEXT(a_result_matches_latch, req_accept,
      rsp_valid_ff && (rsp_states_ff == latch_bits_ff), "result latches disagree with state")

endmodule
